>>> sv/swd_transfer_master_macros.svh
// ----------------------------------------------------------------------------
// swd transfer master assertion macros
// shared property templates for the checker
// ----------------------------------------------------------------------------
`ifndef SWD_TRANSFER_MASTER_MACROS_SVH
`define SWD_TRANSFER_MASTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SWDTM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SWDTM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/swdtm_pkg.sv
// ----------------------------------------------------------------------------
// swdtm_pkg
// types, codes and phase helpers of the swd transfer master
// ----------------------------------------------------------------------------
`default_nettype none

package swdtm_pkg;

    // transfer phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_REQ      = 4'd1;
    localparam logic [3:0] PH_TURN_A   = 4'd2;
    localparam logic [3:0] PH_ACK      = 4'd3;
    localparam logic [3:0] PH_RDATA    = 4'd4;
    localparam logic [3:0] PH_RPAR     = 4'd5;
    localparam logic [3:0] PH_TURN_B   = 4'd6;
    localparam logic [3:0] PH_TURN_W   = 4'd7;
    localparam logic [3:0] PH_WDATA    = 4'd8;
    localparam logic [3:0] PH_WPAR     = 4'd9;
    localparam logic [3:0] PH_IDLE_CLK = 4'd10;
    localparam logic [3:0] PH_DUMMY_R  = 4'd11;
    localparam logic [3:0] PH_TURN_F   = 4'd12;
    localparam logic [3:0] PH_DUMMY_W  = 4'd13;
    localparam logic [3:0] PH_BACKOFF  = 4'd14;

    localparam logic [7:0] REQ_LEN        = 8'd8;
    localparam logic [7:0] ACK_LEN        = 8'd3;
    localparam logic [7:0] DATA_LEN       = 8'd32;
    localparam logic [7:0] DATA_PHASE_LEN = 8'd33;

    // acknowledge codes as received
    localparam logic [2:0] ACK_OK    = 3'd1;
    localparam logic [2:0] ACK_WAIT  = 3'd2;
    localparam logic [2:0] ACK_FAULT = 3'd4;

    // transfer status
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_FAULT  = 3'd2;
    localparam logic [2:0] ST_PROTO  = 3'd3;
    localparam logic [2:0] ST_PARITY = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_TURNAROUND = 2'd0;
    localparam logic [1:0] CFG_IDLE_COUNT = 2'd1;
    localparam logic [1:0] CFG_FORCE_DATA = 2'd2;

    localparam int ITEM_TDATA_W   = 40;
    localparam int RESULT_TDATA_W = 48;

    typedef struct packed {
        logic        is_start;
        logic [3:0]  request;
        logic [31:0] wdata;
        logic        sample;
    } t_item;

    typedef struct packed {
        logic        drive;
        logic        enable;
        logic        busy;
        logic        done;
        logic [2:0]  status;
        logic [2:0]  ack;
        logic [31:0] rdata;
    } t_result;

    function automatic logic [7:0] phase_len(input logic [3:0] ph,
                                             input logic [2:0] ta,
                                             input logic [7:0] idle_cnt);
        logic [7:0] len;
        case (ph)
            PH_REQ:                                    len = REQ_LEN;
            PH_ACK:                                    len = ACK_LEN;
            PH_RDATA, PH_WDATA:                        len = DATA_LEN;
            PH_RPAR, PH_WPAR:                          len = 8'd1;
            PH_TURN_A, PH_TURN_B, PH_TURN_W, PH_TURN_F: len = {5'd0, ta};
            PH_IDLE_CLK:                               len = idle_cnt;
            PH_DUMMY_R, PH_DUMMY_W:                    len = DATA_PHASE_LEN;
            PH_BACKOFF:                                len = {5'd0, ta} + DATA_PHASE_LEN;
            default:                                   len = 8'd0;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] next_phase(input logic [3:0] ph,
                                              input logic [2:0] ack,
                                              input logic       rd,
                                              input logic       force_dp);
        logic [3:0] nxt;
        case (ph)
            PH_REQ:    nxt = PH_TURN_A;
            PH_TURN_A: nxt = PH_ACK;
            PH_ACK: begin
                if (ack == ACK_OK) begin
                    nxt = rd ? PH_RDATA : PH_TURN_W;
                end else if (ack == ACK_WAIT || ack == ACK_FAULT) begin
                    nxt = (force_dp && rd) ? PH_DUMMY_R : PH_TURN_F;
                end else begin
                    nxt = PH_BACKOFF;
                end
            end
            PH_RDATA:   nxt = PH_RPAR;
            PH_RPAR:    nxt = PH_TURN_B;
            PH_TURN_B:  nxt = PH_IDLE_CLK;
            PH_TURN_W:  nxt = PH_WDATA;
            PH_WDATA:   nxt = PH_WPAR;
            PH_WPAR:    nxt = PH_IDLE_CLK;
            PH_DUMMY_R: nxt = PH_TURN_F;
            PH_TURN_F:  nxt = (force_dp && !rd) ? PH_DUMMY_W : PH_IDLE;
            default:    nxt = PH_IDLE;
        endcase
        return nxt;
    endfunction

    // skip phases of zero length; at most two can follow one another
    function automatic logic [3:0] enter_phase(input logic [3:0] ph,
                                               input logic [2:0] ta,
                                               input logic [7:0] idle_cnt,
                                               input logic [2:0] ack,
                                               input logic       rd,
                                               input logic       force_dp);
        logic [3:0] p;
        p = ph;
        for (int i = 0; i < 3; i++) begin
            if (p != PH_IDLE && phase_len(p, ta, idle_cnt) == 8'd0) begin
                p = next_phase(p, ack, rd, force_dp);
            end
        end
        return p;
    endfunction

    // {enable, drive} presented in a phase
    function automatic logic [1:0] pin_state(input logic [3:0] ph,
                                             input logic [7:0] cnt,
                                             input logic [3:0] req,
                                             input logic       data_lsb,
                                             input logic       par);
        logic [7:0] pkt;
        logic [7:0] pos;
        logic [1:0] pins;
        pkt  = {1'b1, 1'b0, ^req, req, 1'b1};
        pos  = REQ_LEN - cnt;
        pins = 2'b01;
        case (ph)
            PH_IDLE:                 pins = 2'b11;
            PH_REQ:                  pins = {1'b1, pkt[pos[2:0]]};
            PH_WDATA:                pins = {1'b1, data_lsb};
            PH_WPAR:                 pins = {1'b1, par};
            PH_IDLE_CLK, PH_DUMMY_W: pins = 2'b10;
            default:                 pins = 2'b01;
        endcase
        return pins;
    endfunction

endpackage

`default_nettype wire

>>> sv/swdtm_front.sv
// ----------------------------------------------------------------------------
// swdtm_front
// takes stream items, sorts them into start and tick, queues them
// ----------------------------------------------------------------------------
`default_nettype none

module swdtm_front #(
    parameter int DEPTH = 2
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    input  wire logic [swdtm_pkg::ITEM_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                                  i_s_tuser,
    output logic                                       o_item_valid,
    input  wire logic                                  i_item_ready,
    output swdtm_pkg::t_item                           o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    swdtm_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    swdtm_pkg::t_item c_in;
    logic             c_push, c_pop;

    always_comb begin
        c_in.is_start = i_s_tuser;
        c_in.request  = i_s_tdata[3:0];
        c_in.wdata    = i_s_tuser ? i_s_tdata[35:4] : 32'd0;
        c_in.sample   = i_s_tuser ? 1'b0 : i_s_tdata[36];
    end

    assign o_s_tready   = (r_count != FULL_CNT);
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rptr];
    assign c_push       = i_s_tvalid && o_s_tready;
    assign c_pop        = o_item_valid && i_item_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (c_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (c_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        case ({c_push, c_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wptr] <= c_in;
        end
    end

endmodule

`default_nettype wire

>>> sv/swdtm_engine.sv
// ----------------------------------------------------------------------------
// swdtm_engine
// runs the transfer phases one swclk tick per item, registers the result
// ----------------------------------------------------------------------------
`default_nettype none

module swdtm_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_addr,
    input  wire logic [7:0]        i_cfg_wdata,
    input  wire logic              i_item_valid,
    output logic                   o_item_ready,
    input  wire swdtm_pkg::t_item  i_item,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output swdtm_pkg::t_result     o_result
);

    logic [2:0]  r_ta;
    logic [7:0]  r_idle_cnt;
    logic        r_force;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    logic        r_par, n_par;
    logic [3:0]  r_req, n_req;
    logic [2:0]  r_ack, n_ack;

    logic                r_out_valid;
    swdtm_pkg::t_result  r_out, n_out;

    logic        c_take;
    logic        c_rd;
    logic [1:0]  c_ack_pos;
    logic [1:0]  c_pins;
    logic [3:0]  c_nxt;

    assign o_item_ready = !r_out_valid || i_m_tready;
    assign c_take       = i_item_valid && o_item_ready;
    assign o_m_tvalid   = r_out_valid;
    assign o_result     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta       <= 3'd1;
            r_idle_cnt <= 8'd0;
            r_force    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                swdtm_pkg::CFG_TURNAROUND: r_ta       <= i_cfg_wdata[2:0];
                swdtm_pkg::CFG_IDLE_COUNT: r_idle_cnt <= i_cfg_wdata;
                swdtm_pkg::CFG_FORCE_DATA: r_force    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_shift   = r_shift;
        n_par     = r_par;
        n_req     = r_req;
        n_ack     = r_ack;
        c_rd      = r_req[1];
        c_ack_pos = 2'd3 - r_cnt[1:0];
        c_nxt     = swdtm_pkg::PH_IDLE;
        c_pins    = 2'b11;

        n_out.drive  = 1'b1;
        n_out.enable = 1'b1;
        n_out.busy   = 1'b0;
        n_out.done   = 1'b0;
        n_out.status = swdtm_pkg::ST_OK;
        n_out.ack    = 3'd0;
        n_out.rdata  = 32'd0;

        if (i_item.is_start) begin
            if (r_phase == swdtm_pkg::PH_IDLE) begin
                n_req   = i_item.request;
                n_shift = i_item.wdata;
                n_par   = 1'b0;
                n_ack   = 3'd0;
                n_phase = swdtm_pkg::PH_REQ;
                n_cnt   = swdtm_pkg::REQ_LEN;
            end
            // a start shows what the next tick will present
            c_pins = swdtm_pkg::pin_state(n_phase, n_cnt, n_req, n_shift[0], n_par);
        end else begin
            c_pins = swdtm_pkg::pin_state(r_phase, r_cnt, r_req, r_shift[0], r_par);
            if (r_phase != swdtm_pkg::PH_IDLE) begin
                case (r_phase)
                    swdtm_pkg::PH_ACK: begin
                        case (c_ack_pos)
                            2'd0:    n_ack = r_ack | {2'b00, i_item.sample};
                            2'd1:    n_ack = r_ack | {1'b0, i_item.sample, 1'b0};
                            2'd2:    n_ack = r_ack | {i_item.sample, 2'b00};
                            default: n_ack = r_ack;
                        endcase
                    end
                    swdtm_pkg::PH_RDATA: begin
                        n_shift = {i_item.sample, r_shift[31:1]};
                        n_par   = r_par ^ i_item.sample;
                    end
                    swdtm_pkg::PH_RPAR: begin
                        n_par = r_par ^ i_item.sample;
                    end
                    swdtm_pkg::PH_WDATA: begin
                        n_par   = r_par ^ r_shift[0];
                        n_shift = {1'b0, r_shift[31:1]};
                    end
                    swdtm_pkg::PH_WPAR: begin
                        n_par = 1'b0;
                    end
                    default: ;
                endcase
                if (r_cnt > 8'd1) begin
                    n_cnt = r_cnt - 8'd1;
                end else begin
                    c_nxt = swdtm_pkg::enter_phase(
                        swdtm_pkg::next_phase(r_phase, n_ack, c_rd, r_force),
                        r_ta, r_idle_cnt, n_ack, c_rd, r_force);
                    n_phase = c_nxt;
                    n_cnt   = swdtm_pkg::phase_len(c_nxt, r_ta, r_idle_cnt);
                end
                if (n_phase == swdtm_pkg::PH_IDLE) begin
                    n_out.done = 1'b1;
                    n_out.ack  = n_ack;
                    if (n_ack == swdtm_pkg::ACK_OK) begin
                        n_out.status = (c_rd && n_par) ? swdtm_pkg::ST_PARITY
                                                       : swdtm_pkg::ST_OK;
                        if (c_rd) begin
                            n_out.rdata = n_shift;
                        end
                    end else if (n_ack == swdtm_pkg::ACK_WAIT) begin
                        n_out.status = swdtm_pkg::ST_WAIT;
                    end else if (n_ack == swdtm_pkg::ACK_FAULT) begin
                        n_out.status = swdtm_pkg::ST_FAULT;
                    end else begin
                        n_out.status = swdtm_pkg::ST_PROTO;
                    end
                end
            end
        end

        n_out.enable = c_pins[1];
        n_out.drive  = c_pins[0];
        n_out.busy   = (n_phase != swdtm_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= swdtm_pkg::PH_IDLE;
            r_cnt       <= 8'd0;
            r_shift     <= 32'd0;
            r_par       <= 1'b0;
            r_req       <= 4'd0;
            r_ack       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (c_take) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_shift <= n_shift;
                r_par   <= n_par;
                r_req   <= n_req;
                r_ack   <= n_ack;
            end
            if (c_take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> sv/swd_transfer_master.sv
// ----------------------------------------------------------------------------
// swd_transfer_master
// host side of one serial wire debug transfer, one swclk tick per item
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// s_axis    in         tvalid/tready             tuser cmd, tdata request/wdata/sample
// m_axis    out        tvalid/tready             tdata pins, busy, done, status, ack, rdata
// cfg       in         i_cfg_we, no wait         i_cfg_addr, i_cfg_wdata
//
// one item per clock while neither side stalls; every item, start or tick, gives one result
// an item passes the queue entry, then the output register
// the engine's phase register and bit counter carry one tick into the next
// synchronous active-low reset empties the queue and parks the engine idle
// either side may stall; the queue holds QUEUE_DEPTH items while the output waits
// ----------------------------------------------------------------------------
`default_nettype none

module swd_transfer_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // request[3:0], wdata[35:4], swdio_sample[36], zero fill
    input  wire logic [39:0] s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // swdio_drive[0], swdio_enable[1], busy_res[2], done_res[3], status[6:4],
    // ack_bits[9:7], rdata[41:10], zero fill
    output logic [47:0]      m_axis_tdata
);

    logic               c_item_valid;
    logic               c_item_ready;
    swdtm_pkg::t_item   c_item;
    swdtm_pkg::t_result c_result;

    swdtm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser[0]),
        .o_item_valid (c_item_valid),
        .i_item_ready (c_item_ready),
        .o_item       (c_item)
    );

    swdtm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (c_item_valid),
        .o_item_ready (c_item_ready),
        .i_item       (c_item),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_result     (c_result)
    );

    assign m_axis_tdata = {6'd0, c_result.rdata, c_result.ack, c_result.status,
                           c_result.done, c_result.busy, c_result.enable,
                           c_result.drive};

endmodule

`default_nettype wire

>>> sv/swdtm_checker.sv
// ----------------------------------------------------------------------------
// swdtm_checker
// port-level checks of the swd transfer master, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "swd_transfer_master_macros.svh"

module swdtm_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata
);

    logic c_done;
    logic c_busy;
    logic c_quiet;

    assign c_done  = m_axis_tdata[3];
    assign c_busy  = m_axis_tdata[2];
    assign c_quiet = (m_axis_tdata[47:4] == 44'd0);

    // the done item closes the transfer
    `SWDTM_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, m_axis_tvalid && c_done, !c_busy, "done item still busy")

    // status, ack and read data stay zero outside the done item
    `SWDTM_ASSERT_IMP(a_quiet_unless_done, i_clk, i_rst_n, m_axis_tvalid && !c_done, c_quiet, "status fields set outside done")

    // an idle item parks the line driven high
    `SWDTM_ASSERT_IMP(a_idle_parked, i_clk, i_rst_n, m_axis_tvalid && !c_busy && !c_done, m_axis_tdata[1:0] == 2'b11, "idle item not parked high")

    // a stalled result holds
    `SWDTM_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind swd_transfer_master swdtm_checker u_swdtm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb - swd_transfer_master testbench
// drives start and tick items into the stream input and checks every line
// state against a cycle-free model of the transfer sequence; acknowledge and
// read parity bits are steered to reach ok, wait, fault, protocol error and
// parity error endings under several register settings
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 200000;

    // tracks the transfer engine and holds the line states still owed
    class swd_line_model;
        logic [2:0]  ta_clocks;
        logic [7:0]  idle_clocks;
        logic        force_dp;
        logic [3:0]  ph;
        logic [7:0]  cnt;
        logic [31:0] shreg;
        logic        par;
        logic [3:0]  req;
        logic [2:0]  ack;
        swdtm_pkg::t_result line_results_due[$];
        int          errors;

        function new();
            ta_clocks   = 3'd1;
            idle_clocks = 8'd0;
            force_dp    = 1'b0;
            ph          = swdtm_pkg::PH_IDLE;
            cnt         = 8'd0;
            shreg       = 32'd0;
            par         = 1'b0;
            req         = 4'd0;
            ack         = 3'd0;
            errors      = 0;
        endfunction

        function logic [7:0] span(logic [3:0] p);
            case (p)
                swdtm_pkg::PH_REQ:   return swdtm_pkg::REQ_LEN;
                swdtm_pkg::PH_ACK:   return swdtm_pkg::ACK_LEN;
                swdtm_pkg::PH_RDATA,
                swdtm_pkg::PH_WDATA: return swdtm_pkg::DATA_LEN;
                swdtm_pkg::PH_RPAR,
                swdtm_pkg::PH_WPAR:  return 8'd1;
                swdtm_pkg::PH_TURN_A, swdtm_pkg::PH_TURN_B,
                swdtm_pkg::PH_TURN_W, swdtm_pkg::PH_TURN_F:
                    return {5'd0, ta_clocks};
                swdtm_pkg::PH_IDLE_CLK: return idle_clocks;
                swdtm_pkg::PH_DUMMY_R,
                swdtm_pkg::PH_DUMMY_W:  return swdtm_pkg::DATA_PHASE_LEN;
                swdtm_pkg::PH_BACKOFF:
                    return {5'd0, ta_clocks} + swdtm_pkg::DATA_PHASE_LEN;
                default: return 8'd0;
            endcase
        endfunction

        function logic [3:0] successor(logic [3:0] p);
            logic rd;
            rd = req[1];
            case (p)
                swdtm_pkg::PH_REQ:    return swdtm_pkg::PH_TURN_A;
                swdtm_pkg::PH_TURN_A: return swdtm_pkg::PH_ACK;
                swdtm_pkg::PH_ACK: begin
                    if (ack == swdtm_pkg::ACK_OK)
                        return rd ? swdtm_pkg::PH_RDATA : swdtm_pkg::PH_TURN_W;
                    if (ack == swdtm_pkg::ACK_WAIT || ack == swdtm_pkg::ACK_FAULT)
                        return (force_dp && rd) ? swdtm_pkg::PH_DUMMY_R
                                                : swdtm_pkg::PH_TURN_F;
                    return swdtm_pkg::PH_BACKOFF;
                end
                swdtm_pkg::PH_RDATA:   return swdtm_pkg::PH_RPAR;
                swdtm_pkg::PH_RPAR:    return swdtm_pkg::PH_TURN_B;
                swdtm_pkg::PH_TURN_B:  return swdtm_pkg::PH_IDLE_CLK;
                swdtm_pkg::PH_TURN_W:  return swdtm_pkg::PH_WDATA;
                swdtm_pkg::PH_WDATA:   return swdtm_pkg::PH_WPAR;
                swdtm_pkg::PH_WPAR:    return swdtm_pkg::PH_IDLE_CLK;
                swdtm_pkg::PH_DUMMY_R: return swdtm_pkg::PH_TURN_F;
                swdtm_pkg::PH_TURN_F:
                    return (force_dp && !rd) ? swdtm_pkg::PH_DUMMY_W
                                             : swdtm_pkg::PH_IDLE;
                default:    return swdtm_pkg::PH_IDLE;
            endcase
        endfunction

        // empty phases fall straight through to the next one
        function void start_phase(logic [3:0] p);
            while (p != swdtm_pkg::PH_IDLE && span(p) == 8'd0)
                p = successor(p);
            ph  = p;
            cnt = span(p);
        endfunction

        function void line_pins(output logic drv, output logic en);
            logic [7:0] pkt;
            logic [7:0] pos;
            drv = 1'b1;
            en  = 1'b0;
            case (ph)
                swdtm_pkg::PH_IDLE: en = 1'b1;
                swdtm_pkg::PH_REQ: begin
                    pkt = 8'h81 | ({7'd0, ^req} << 5) | ({4'd0, req} << 1);
                    pos = swdtm_pkg::REQ_LEN - cnt;
                    drv = pkt[pos[2:0]];
                    en  = 1'b1;
                end
                swdtm_pkg::PH_WDATA: begin
                    drv = shreg[0];
                    en  = 1'b1;
                end
                swdtm_pkg::PH_WPAR: begin
                    drv = par;
                    en  = 1'b1;
                end
                swdtm_pkg::PH_IDLE_CLK, swdtm_pkg::PH_DUMMY_W: begin
                    drv = 1'b0;
                    en  = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void note_item(logic cmd, logic [3:0] rq, logic [31:0] wd, logic smp);
            swdtm_pkg::t_result r;
            logic        drv;
            logic        en;
            logic        done;
            logic [2:0]  st;
            logic [2:0]  ackb;
            logic [31:0] rdv;
            int          pos;
            done = 1'b0;
            st   = swdtm_pkg::ST_OK;
            ackb = 3'd0;
            rdv  = 32'd0;
            if (cmd) begin
                // a start only latches; it never clocks the line
                if (ph == swdtm_pkg::PH_IDLE) begin
                    req   = rq;
                    shreg = wd;
                    par   = 1'b0;
                    ack   = 3'd0;
                    start_phase(swdtm_pkg::PH_REQ);
                end
                line_pins(drv, en);
            end else begin
                line_pins(drv, en);
                if (ph != swdtm_pkg::PH_IDLE) begin
                    case (ph)
                        swdtm_pkg::PH_ACK: begin
                            pos = int'(swdtm_pkg::ACK_LEN) - int'(cnt);
                            if (pos >= 0 && pos < 3) ack[pos] = ack[pos] | smp;
                        end
                        swdtm_pkg::PH_RDATA: begin
                            shreg = {smp, shreg[31:1]};
                            par   = par ^ smp;
                        end
                        swdtm_pkg::PH_RPAR:  par = par ^ smp;
                        swdtm_pkg::PH_WDATA: begin
                            par   = par ^ shreg[0];
                            shreg = shreg >> 1;
                        end
                        swdtm_pkg::PH_WPAR:  par = 1'b0;
                        default: ;
                    endcase
                    if (cnt > 8'd1) begin
                        cnt = cnt - 8'd1;
                    end else begin
                        cnt = 8'd0;
                        start_phase(successor(ph));
                    end
                    if (ph == swdtm_pkg::PH_IDLE) begin
                        done = 1'b1;
                        ackb = ack;
                        if (ack == swdtm_pkg::ACK_OK) begin
                            st = (req[1] && par) ? swdtm_pkg::ST_PARITY : swdtm_pkg::ST_OK;
                            if (req[1]) rdv = shreg;
                        end else if (ack == swdtm_pkg::ACK_WAIT) begin
                            st = swdtm_pkg::ST_WAIT;
                        end else if (ack == swdtm_pkg::ACK_FAULT) begin
                            st = swdtm_pkg::ST_FAULT;
                        end else begin
                            st = swdtm_pkg::ST_PROTO;
                        end
                    end
                end
            end
            r.drive  = drv;
            r.enable = en;
            r.busy   = (ph != swdtm_pkg::PH_IDLE);
            r.done   = done;
            r.status = st;
            r.ack    = ackb;
            r.rdata  = rdv;
            line_results_due.push_back(r);
        endfunction

        function void same(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                errors++;
            end
        endfunction

        function void match_result(logic [47:0] td);
            swdtm_pkg::t_result want;
            if (line_results_due.size() == 0) begin
                $error("result with nothing expected: %0h", td);
                errors++;
                return;
            end
            want = line_results_due.pop_front();
            same("swdio_drive", want.drive, td[0]);
            same("swdio_enable", want.enable, td[1]);
            same("busy_res", want.busy, td[2]);
            same("done_res", want.done, td[3]);
            same("status", want.status, td[6:4]);
            same("ack_bits", want.ack, td[9:7]);
            same("rdata", want.rdata, td[41:10]);
        endfunction

        function int pending();
            return line_results_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = 2'd0;
    logic [7:0]  i_cfg_wdata   = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = 40'd0;
    logic [0:0]  s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    swd_line_model model;
    int            cycles     = 0;
    int            items_sent = 0;
    bit            calm       = 1'b0;

    swd_transfer_master i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiving side: check accepted results, stall at random
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) model.match_result(m_axis_tdata);
        m_axis_tready <= calm || ($urandom_range(99) >= 21);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL swd_transfer_master");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [3:0] rq, input logic [31:0] wd,
                             input logic smp);
        if (!calm) begin
            while ($urandom_range(99) < 21) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'd0, smp, wd, rq};
        do @(posedge i_clk); while (!s_axis_tready);
        model.note_item(cmd, rq, wd, smp);
        items_sent++;
    endtask

    // hold the sender back until every owed result is in
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (model.pending() != 0);
    endtask

    task automatic set_regs(input logic [2:0] ta, input logic [7:0] idle_cnt, input logic fdp);
        wait_drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= swdtm_pkg::CFG_TURNAROUND;
        i_cfg_wdata <= {5'd0, ta};
        @(posedge i_clk);
        i_cfg_addr  <= swdtm_pkg::CFG_IDLE_COUNT;
        i_cfg_wdata <= idle_cnt;
        @(posedge i_clk);
        i_cfg_addr  <= swdtm_pkg::CFG_FORCE_DATA;
        i_cfg_wdata <= {7'd0, fdp};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model.ta_clocks   = ta;
        model.idle_clocks = idle_cnt;
        model.force_dp    = fdp;
    endtask

    // line level the target would present for the next tick
    function automatic logic line_sample(input logic [2:0] ack_code, input logic bad_par);
        int pos;
        if (model.ph == swdtm_pkg::PH_ACK) begin
            pos = int'(swdtm_pkg::ACK_LEN) - int'(model.cnt);
            return ack_code[pos];
        end
        if (model.ph == swdtm_pkg::PH_RPAR) return model.par ^ bad_par;
        return 1'($urandom_range(1));
    endfunction

    task automatic run_transfer(input logic [3:0] rq, input logic [31:0] wd,
                                input logic [2:0] ack_code, input logic bad_par,
                                input logic busy_start);
        send_item(1'b1, rq, wd, 1'($urandom_range(1)));
        if (busy_start) send_item(1'b1, ~rq, ~wd, 1'b0);
        while (model.ph != swdtm_pkg::PH_IDLE) begin
            if ($urandom_range(99) < 3)
                send_item(1'b1, 4'($urandom), $urandom, 1'($urandom_range(1)));
            else if ($urandom_range(499) == 0)
                wait_drain();
            else
                send_item(1'b0, 4'($urandom), $urandom, line_sample(ack_code, bad_par));
        end
    endtask

    task automatic random_phase(input logic [2:0] ta, input logic [7:0] idle_cnt,
                                input logic fdp, input int budget);
        int         first;
        int         pick;
        logic [2:0] ack_code;
        set_regs(ta, idle_cnt, fdp);
        first = items_sent;
        while (items_sent - first < budget) begin
            if ($urandom_range(99) < 10)
                send_item(1'b0, 4'($urandom), $urandom, 1'($urandom_range(1)));
            pick = $urandom_range(99);
            if (pick < 55) begin
                ack_code = swdtm_pkg::ACK_OK;
            end else if (pick < 70) begin
                ack_code = swdtm_pkg::ACK_WAIT;
            end else if (pick < 85) begin
                ack_code = swdtm_pkg::ACK_FAULT;
            end else begin
                // malformed acknowledge, leads to the back-off
                do ack_code = 3'($urandom);
                while (ack_code == swdtm_pkg::ACK_OK || ack_code == swdtm_pkg::ACK_WAIT ||
                       ack_code == swdtm_pkg::ACK_FAULT);
            end
            run_transfer(4'($urandom), $urandom, ack_code, $urandom_range(99) < 20, 1'b0);
        end
    endtask

    initial begin
        model = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ticks while idle, then short wait and fault transfers at the field extremes
        send_item(1'b0, 4'hf, 32'hffff_ffff, 1'b1);
        send_item(1'b0, 4'h0, 32'h0, 1'b0);
        run_transfer(4'hf, 32'hffff_ffff, swdtm_pkg::ACK_WAIT, 1'b0, 1'b1);
        run_transfer(4'h0, 32'h0, swdtm_pkg::ACK_FAULT, 1'b0, 1'b0);

        // the last transfer of each run overshoots its budget
        random_phase(3'd0, 8'd0, 1'b1, 150);
        calm = 1'b1;
        random_phase(3'd4, 8'd0, 1'b0, 150);
        calm = 1'b0;
        random_phase(3'd2, 8'd3, 1'b1, 150);
        random_phase(3'd7, 8'd1, 1'b0, 150);
        random_phase(3'd3, 8'd255, 1'b1, 150);
        random_phase(3'd1, 8'd0, 1'b0, 150);
        random_phase(3'd4, 8'd2, 1'b1, 150);
        random_phase(3'd0, 8'd5, 1'b0, 150);

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (model.errors == 0 && model.pending() == 0)
            $display("PASS swd_transfer_master");
        else
            $display("FAIL swd_transfer_master");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/swdtm_pkg.sv
sv/swdtm_front.sv
sv/swdtm_engine.sv
sv/swd_transfer_master.sv
sv/swdtm_checker.sv
dv/tb.sv
